[hw/rtl/srsm_pkg.sv]
// ----------------------------------------------------------------------------
// srsm_pkg
// Shared types, constants and microcode encoding for the speed-ramp sequencer.
// ----------------------------------------------------------------------------
package srsm_pkg;

  localparam int SPEED_W = 16;
  localparam int STAGE_W = 8;
  // (stage + 1) * speed needs one bit more than stage * speed
  localparam int PROD_W  = SPEED_W + STAGE_W + 1;
  localparam int CNT_W   = $clog2(PROD_W);
  localparam int STEP_W  = 3;
  localparam int ROM_DEPTH = 1 << STEP_W;

  localparam logic [STAGE_W-1:0] DEFAULT_STAGES = STAGE_W'(50);
  localparam logic [STAGE_W-1:0] STAGE_MAX      = '1;

  // register indexes on the configuration port
  localparam logic [7:0] REG_ACCEL_STAGES = 8'd0;
  localparam logic [7:0] REG_DECEL_STAGES = 8'd1;

  // input operation codes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // ramp phase codes as seen on the result stream
  localparam logic [1:0] PH_STOP  = 2'd0;
  localparam logic [1:0] PH_ACCEL = 2'd1;
  localparam logic [1:0] PH_CONST = 2'd2;
  localparam logic [1:0] PH_DECEL = 2'd3;

  // microprogram step addresses
  localparam logic [STEP_W-1:0] STEP_WAIT = 3'd0;
  localparam logic [STEP_W-1:0] STEP_MUL  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_DIV  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_FIX  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_EMIT = 3'd4;
  localparam logic [STEP_W-1:0] STEP_RET  = 3'd5;

  typedef enum logic [2:0] {
    UOP_NOP,
    UOP_WAIT,
    UOP_MUL,
    UOP_DIV,
    UOP_FIX,
    UOP_EMIT
  } uop_e;

  typedef enum logic [2:0] {
    COND_NOT_UPD,
    COND_NO_RAMP,
    COND_CNT_NZ,
    COND_OUT_BUSY,
    COND_ALWAYS
  } cond_e;

  typedef struct packed {
    uop_e              uop;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic no_ramp;
    logic cnt_nz;
    logic out_busy;
  } status_t;

endpackage

[hw/rtl/speed_ramp_state_machine_unit.sv]
// ----------------------------------------------------------------------------
// speed_ramp_state_machine_unit
// Trapezoidal speed-ramp sequencer driven by a microcoded step counter.
// ----------------------------------------------------------------------------
// Tick transactions give no result.
// Updates that leave the ramp in stop or constant phase skip the divider,
// while ramp updates run the 25-step radix-2 divider and a fix-up step.
// The emit step waits while the output is stalled, and no new input is
// taken until the result has been loaded into the output register.
// Reset clears phase, stage count, held and previous speed; both stage
// registers return to 50.
module speed_ramp_state_machine_unit
  import srsm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: [15:0] commanded_speed, [31:16] measured_speed
  input  logic [31:0] s_axis_tdata,
  // tuser: [0] operation
  input  logic        s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: [1:0] ramp_phase, [17:2] setpoint_speed, [18] stall_res, [23:19] zero
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_addr_i,
  input  logic [7:0]  cfg_data_i
);

  logic [STEP_W-1:0]  step_q, step_d;
  ctrl_t              ctrl;
  status_t            status;
  logic               in_fire;
  logic               cond_hit;
  logic [STAGE_W-1:0] accel_q, decel_q;
  logic [1:0]         out_phase;
  logic [SPEED_W-1:0] out_sp;
  logic               out_stall;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q <= DEFAULT_STAGES;
      decel_q <= DEFAULT_STAGES;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        REG_ACCEL_STAGES: accel_q <= cfg_data_i;
        REG_DECEL_STAGES: decel_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready = (ctrl.uop == UOP_WAIT);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  srsm_ucode_rom u_rom (
    .step_i (step_q),
    .ctrl_o (ctrl)
  );

  always_comb begin
    case (ctrl.cond)
      COND_NOT_UPD:  cond_hit = !(in_fire && (s_axis_tuser == OP_UPDATE));
      COND_NO_RAMP:  cond_hit = status.no_ramp;
      COND_CNT_NZ:   cond_hit = status.cnt_nz;
      COND_OUT_BUSY: cond_hit = status.out_busy;
      COND_ALWAYS:   cond_hit = 1'b1;
      default:       cond_hit = 1'b1;
    endcase
    // the fix-up step always falls through to emit
    if (ctrl.uop == UOP_FIX) begin
      cond_hit = 1'b1;
    end
    step_d = cond_hit ? ctrl.target : (step_q + STEP_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  srsm_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .in_fire_i      (in_fire),
    .in_op_i        (s_axis_tuser),
    .in_cmd_i       (s_axis_tdata[15:0]),
    .in_meas_i      (s_axis_tdata[31:16]),
    .accel_stages_i (accel_q),
    .decel_stages_i (decel_q),
    .status_o       (status),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_phase_o    (out_phase),
    .out_setpoint_o (out_sp),
    .out_stall_o    (out_stall)
  );

  assign m_axis_tdata = {5'b0, out_stall, out_sp, out_phase};

endmodule

[hw/rtl/srsm_ucode_rom.sv]
// ----------------------------------------------------------------------------
// srsm_ucode_rom
// Read-only microprogram: one control word per sequencer step.
// ----------------------------------------------------------------------------
module srsm_ucode_rom
  import srsm_pkg::*;
(
  input  logic [STEP_W-1:0] step_i,
  output ctrl_t             ctrl_o
);

  // a jump is taken when its condition holds, otherwise the step advances
  always_comb begin
    case (step_i)
      STEP_WAIT: ctrl_o = '{uop: UOP_WAIT, cond: COND_NOT_UPD,  target: STEP_WAIT};
      STEP_MUL:  ctrl_o = '{uop: UOP_MUL,  cond: COND_NO_RAMP,  target: STEP_EMIT};
      STEP_DIV:  ctrl_o = '{uop: UOP_DIV,  cond: COND_CNT_NZ,   target: STEP_DIV};
      STEP_FIX:  ctrl_o = '{uop: UOP_FIX,  cond: COND_NOT_UPD,  target: STEP_EMIT};
      STEP_EMIT: ctrl_o = '{uop: UOP_EMIT, cond: COND_OUT_BUSY, target: STEP_EMIT};
      STEP_RET:  ctrl_o = '{uop: UOP_NOP,  cond: COND_ALWAYS,   target: STEP_WAIT};
      default:   ctrl_o = '{uop: UOP_NOP,  cond: COND_ALWAYS,   target: STEP_WAIT};
    endcase
  end

endmodule

[hw/rtl/srsm_datapath.sv]
// ----------------------------------------------------------------------------
// srsm_datapath
// Ramp state, multiplier, radix-2 divider and result register.
// ----------------------------------------------------------------------------
module srsm_datapath
  import srsm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_t               ctrl_i,
  input  logic                in_fire_i,
  input  logic                in_op_i,
  input  logic [SPEED_W-1:0]  in_cmd_i,
  input  logic [SPEED_W-1:0]  in_meas_i,
  input  logic [STAGE_W-1:0]  accel_stages_i,
  input  logic [STAGE_W-1:0]  decel_stages_i,
  output status_t             status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          out_phase_o,
  output logic [SPEED_W-1:0]  out_setpoint_o,
  output logic                out_stall_o
);

  logic [1:0]         phase_q, phase_d;
  logic [STAGE_W-1:0] stage_q, stage_d;
  logic [SPEED_W-1:0] prev_q, prev_d;
  logic [SPEED_W-1:0] held_q, held_d;

  logic [SPEED_W-1:0] cmd_q;
  logic [SPEED_W-1:0] sp_q;
  logic               stall_q;
  logic [PROD_W-1:0]  quo_q;
  logic [STAGE_W-1:0] rem_q;
  logic [STAGE_W-1:0] div_q;
  logic [CNT_W-1:0]   cnt_q;

  logic               ovalid_q;
  logic [1:0]         ophase_q;
  logic [SPEED_W-1:0] osp_q;
  logic               ostall_q;

  logic [STAGE_W-1:0] accel_n, decel_n;
  logic               upd_fire, tick_fire;
  logic               out_busy;

  logic [STAGE_W:0]   mul_a;
  logic [SPEED_W-1:0] mul_b;
  logic [STAGE_W:0]   trial;
  logic               q_bit;
  logic [PROD_W-1:0]  cmd_ext, held_ext;

  // a stage count of zero counts as one
  assign accel_n = (accel_stages_i == '0) ? STAGE_W'(1) : accel_stages_i;
  assign decel_n = (decel_stages_i == '0) ? STAGE_W'(1) : decel_stages_i;

  assign upd_fire  = in_fire_i && (in_op_i == OP_UPDATE) && (ctrl_i.uop == UOP_WAIT);
  assign tick_fire = in_fire_i && (in_op_i == OP_TICK)   && (ctrl_i.uop == UOP_WAIT);
  assign out_busy  = ovalid_q && !out_ready_i;

  // phase transition on an update, stage advance on a tick
  always_comb begin
    phase_d = phase_q;
    stage_d = stage_q;
    prev_d  = prev_q;
    held_d  = held_q;
    if (tick_fire) begin
      if ((phase_q == PH_ACCEL || phase_q == PH_DECEL) && stage_q != STAGE_MAX) begin
        stage_d = stage_q + STAGE_W'(1);
      end
    end else if (upd_fire) begin
      case (phase_q)
        PH_STOP: begin
          if (in_cmd_i == '0) begin
            stage_d = '0;
          end else begin
            phase_d = PH_ACCEL;
          end
        end
        PH_ACCEL: begin
          if (stage_q >= accel_n) begin
            if (in_meas_i == '0) begin
              phase_d = PH_STOP;
            end else begin
              phase_d = PH_CONST;
              stage_d = '0;
            end
          end
        end
        PH_CONST: begin
          // a drop to zero is also a drop below the previous command
          if (in_cmd_i < prev_q) begin
            phase_d = PH_DECEL;
          end
        end
        default: begin
          if (stage_q >= decel_n) begin
            phase_d = PH_STOP;
            stage_d = '0;
          end
        end
      endcase
      if (phase_d == PH_CONST) begin
        held_d = in_cmd_i;
      end
      prev_d = in_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_STOP;
      stage_q <= '0;
      prev_q  <= '0;
      held_q  <= '0;
    end else begin
      phase_q <= phase_d;
      stage_q <= stage_d;
      prev_q  <= prev_d;
      held_q  <= held_d;
    end
  end

  // operand selection for the ramp product
  assign mul_a = (phase_q == PH_ACCEL) ? {1'b0, stage_q}
                                       : ({1'b0, stage_q} + (STAGE_W+1)'(1));
  assign mul_b = (phase_q == PH_ACCEL) ? cmd_q : held_q;

  // one restoring divide step
  assign trial = {rem_q, quo_q[PROD_W-1]};
  assign q_bit = (trial >= {1'b0, div_q});

  assign cmd_ext  = PROD_W'(cmd_q);
  assign held_ext = PROD_W'(held_q);

  always_ff @(posedge clk_i) begin
    case (ctrl_i.uop)
      UOP_WAIT: begin
        if (upd_fire) begin
          cmd_q   <= in_cmd_i;
          sp_q    <= (phase_d == PH_CONST) ? in_cmd_i : '0;
          stall_q <= (phase_d == PH_CONST) && (in_meas_i == '0);
        end
      end
      UOP_MUL: begin
        quo_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
        rem_q <= '0;
        div_q <= (phase_q == PH_ACCEL) ? accel_n : decel_n;
        cnt_q <= CNT_W'(PROD_W - 1);
      end
      UOP_DIV: begin
        rem_q <= q_bit ? STAGE_W'(trial - {1'b0, div_q}) : trial[STAGE_W-1:0];
        quo_q <= {quo_q[PROD_W-2:0], q_bit};
        cnt_q <= cnt_q - CNT_W'(1);
      end
      UOP_FIX: begin
        if (phase_q == PH_ACCEL) begin
          sp_q <= (quo_q <= cmd_ext) ? quo_q[SPEED_W-1:0] : cmd_q;
        end else begin
          sp_q <= (quo_q >= held_ext) ? '0 : SPEED_W'(held_ext - quo_q);
        end
      end
      default: begin
      end
    endcase
  end

  // result register, loaded once the previous result is gone or being taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (ctrl_i.uop == UOP_EMIT && !out_busy) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.uop == UOP_EMIT && !out_busy) begin
      ophase_q <= phase_q;
      osp_q    <= sp_q;
      ostall_q <= stall_q;
    end
  end

  assign status_o.no_ramp  = (phase_q == PH_STOP) || (phase_q == PH_CONST);
  assign status_o.cnt_nz   = (cnt_q != '0);
  assign status_o.out_busy = out_busy;

  assign out_valid_o    = ovalid_q;
  assign out_phase_o    = ophase_q;
  assign out_setpoint_o = osp_q;
  assign out_stall_o    = ostall_q;

endmodule

[tb/sv/speed_ramp_state_machine_unit_tb.sv]
// ----------------------------------------------------------------------------
// speed_ramp_state_machine_unit_tb
// Self-checking bench for the trapezoidal speed-ramp sequencer. A directed
// table walks the phase transitions and corner cases, then random ramp
// sequences under several stage settings are scored against a built-in
// predictor, with random input gaps and random back-pressure on the output.
// ----------------------------------------------------------------------------
module speed_ramp_state_machine_unit_tb;
  import srsm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SETTLE_CYCLES = 40;
  localparam int          HOLD_CYCLES   = 300;
  localparam logic [7:0]  REG_ABSENT    = 8'hFE;
  localparam int          N_ROWS        = 26;
  localparam int          N_PLANS       = 8;
  localparam logic [7:0]  PLAN_ACCEL [N_PLANS] =
    '{8'd50, 8'd1, 8'd255, 8'd4, 8'd0, 8'd7, 8'd2, 8'd0};
  localparam logic [7:0]  PLAN_DECEL [N_PLANS] =
    '{8'd50, 8'd1, 8'd255, 8'd9, 8'd3, 8'd2, 8'd255, 8'd0};
  localparam int          PLAN_BUDGET [N_PLANS] = '{40, 30, 60, 30, 30, 30, 40, 40};

  typedef struct packed {
    logic [1:0]  ramp_phase;
    logic [15:0] setpoint_speed;
    logic        stall_res;
  } ramp_result_t;

  typedef struct packed {
    logic         is_cfg;
    logic         op;
    logic [15:0]  cmd;
    logic [15:0]  meas;
    logic [7:0]   addr;
    logic [7:0]   wdata;
    logic         typed;
    ramp_result_t want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_addr_i;
  logic [7:0]  cfg_data_i;

  // predictor state
  logic [1:0]  phase_q;
  logic [7:0]  stage_q;
  logic [15:0] prev_cmd_q;
  logic [15:0] held_q;
  logic [7:0]  accel_cfg;
  logic [7:0]  decel_cfg;
  logic [15:0] cruise_cmd;

  ramp_result_t ramp_outcomes [$];
  dir_row_t     directed_rows [N_ROWS];
  bit           no_gaps;
  int unsigned  mismatches;
  int unsigned  results_seen;

  always #4 clk_i = ~clk_i;

  speed_ramp_state_machine_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  function automatic dir_row_t row_item(logic op, logic [15:0] cmd, logic [15:0] meas);
    dir_row_t r;
    r      = '0;
    r.op   = op;
    r.cmd  = cmd;
    r.meas = meas;
    return r;
  endfunction

  function automatic dir_row_t row_known(logic [15:0] cmd, logic [15:0] meas,
                                         logic [1:0] ph, logic [15:0] sp, logic st);
    dir_row_t r;
    r                     = row_item(OP_UPDATE, cmd, meas);
    r.typed               = 1'b1;
    r.want.ramp_phase     = ph;
    r.want.setpoint_speed = sp;
    r.want.stall_res      = st;
    return r;
  endfunction

  function automatic dir_row_t row_write(logic [7:0] addr, logic [7:0] data);
    dir_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.addr   = addr;
    r.wdata  = data;
    return r;
  endfunction

  function automatic logic [15:0] rand_speed(int unsigned zero_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < zero_pct) return 16'h0000;
    if (r < zero_pct + 8) return 16'hFFFF;
    return 16'($urandom_range(1, 65535));
  endfunction

  function automatic void flag_mismatch(string what, logic [15:0] exp_v, logic [15:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0h got %0h at %0t", what, exp_v, got_v, $time);
  endfunction

  // phase sequencer: advances state for one transaction, gives the result of an update
  task automatic step_ramp(input logic op, input logic [15:0] cmd, input logic [15:0] meas,
                           output bit produced, output ramp_result_t res);
    logic [31:0] acc_lim;
    logic [31:0] dec_lim;
    logic [31:0] prod;
    acc_lim  = (accel_cfg == 8'd0) ? 32'd1 : 32'(accel_cfg);
    dec_lim  = (decel_cfg == 8'd0) ? 32'd1 : 32'(decel_cfg);
    produced = 1'b0;
    res      = '0;
    if (op == OP_TICK) begin
      if ((phase_q == PH_ACCEL || phase_q == PH_DECEL) && stage_q != STAGE_MAX)
        stage_q = stage_q + 8'd1;
      return;
    end
    case (phase_q)
      PH_STOP: begin
        if (cmd == 16'h0000) stage_q = '0;
        else phase_q = PH_ACCEL;
      end
      PH_ACCEL: begin
        if (32'(stage_q) >= acc_lim) begin
          if (meas == 16'h0000) begin
            phase_q = PH_STOP;  // count kept for the restart
          end else begin
            phase_q = PH_CONST;
            stage_q = '0;
          end
        end
      end
      PH_CONST: begin
        if (cmd != prev_cmd_q && (cmd < prev_cmd_q || cmd == 16'h0000)) phase_q = PH_DECEL;
      end
      default: begin
        if (32'(stage_q) >= dec_lim) begin
          phase_q = PH_STOP;
          stage_q = '0;
        end
      end
    endcase
    if (phase_q == PH_CONST) held_q = cmd;
    case (phase_q)
      PH_ACCEL: begin
        prod = 32'(stage_q) * 32'(cmd) / acc_lim;
        res.setpoint_speed = (prod > 32'(cmd)) ? cmd : prod[15:0];
      end
      PH_CONST: res.setpoint_speed = cmd;
      PH_DECEL: begin
        prod = (32'(stage_q) + 32'd1) * 32'(held_q) / dec_lim;
        res.setpoint_speed = (prod >= 32'(held_q)) ? 16'h0000 : held_q - prod[15:0];
      end
      default: res.setpoint_speed = 16'h0000;
    endcase
    prev_cmd_q     = cmd;
    res.ramp_phase = phase_q;
    res.stall_res  = (phase_q == PH_CONST && meas == 16'h0000);
    produced       = 1'b1;
  endtask

  // mostly well-formed ramps: start, tick through the stages, cruise, slow down
  task automatic pick_item(output logic op, output logic [15:0] cmd, output logic [15:0] meas);
    int unsigned roll;
    int unsigned lim;
    int unsigned tick_pct;
    int unsigned bump;
    roll = $urandom_range(0, 99);
    op   = OP_UPDATE;
    cmd  = cruise_cmd;
    meas = rand_speed(15);
    case (phase_q)
      PH_STOP: begin
        if (roll < 80) begin
          cruise_cmd = rand_speed(0);
          cmd        = cruise_cmd;
        end else if (roll < 90) begin
          cmd = 16'h0000;
        end else begin
          op = OP_TICK;
        end
      end
      PH_ACCEL: begin
        lim      = (accel_cfg == 8'd0) ? 1 : accel_cfg;
        tick_pct = (lim > 16) ? 95 : 60;
        if (stage_q < lim && roll < tick_pct) op = OP_TICK;
        else if (roll >= 90) cmd = rand_speed(5);
        if (stage_q >= lim && $urandom_range(0, 5) == 0) meas = 16'h0000;
      end
      PH_CONST: begin
        bump = $urandom_range(0, 500);
        if (roll < 10) op = OP_TICK;
        else if (roll < 30) cmd = prev_cmd_q;
        else if (roll < 70)
          cmd = (32'(prev_cmd_q) + bump > 32'hFFFF) ? 16'hFFFF : prev_cmd_q + 16'(bump);
        else if (roll < 88)
          cmd = (prev_cmd_q == 16'h0000) ? 16'h0000 :
                16'($urandom_range(0, 32'(prev_cmd_q) - 1));
        else cmd = 16'h0000;
      end
      default: begin
        lim      = (decel_cfg == 8'd0) ? 1 : decel_cfg;
        tick_pct = (lim > 16) ? 95 : 60;
        if (stage_q < lim && roll < tick_pct) op = OP_TICK;
        else cmd = rand_speed(20);
      end
    endcase
  endtask

  task automatic feed_item(input logic op, input logic [15:0] cmd, input logic [15:0] meas,
                           input bit typed, input ramp_result_t known);
    int unsigned  gap;
    bit           produced;
    ramp_result_t res;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {meas, cmd};
    s_axis_tuser  = op;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    step_ramp(op, cmd, meas, produced, res);
    if (produced) ramp_outcomes.push_back(typed ? known : res);
  endtask

  // wait for the block to drain; ticks leave nothing behind to wait on
  task automatic settle_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (ramp_outcomes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [7:0] addr, input logic [7:0] data);
    @(negedge clk_i);
    cfg_addr_i  = addr;
    cfg_data_i  = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (addr == REG_ACCEL_STAGES) accel_cfg = data;
    else if (addr == REG_DECEL_STAGES) decel_cfg = data;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin : stimulus
    logic        op;
    logic [15:0] cmd;
    logic [15:0] meas;
    logic [7:0]  acc_v;
    logic [7:0]  dec_v;
    int unsigned counted;
    int unsigned burst;
    bit          sat_done;
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_UPDATE;
    s_axis_tvalid = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_addr_i    = '0;
    cfg_data_i    = '0;
    no_gaps       = 1'b0;
    mismatches    = 0;
    phase_q       = PH_STOP;
    stage_q       = '0;
    prev_cmd_q    = '0;
    held_q        = '0;
    accel_cfg     = DEFAULT_STAGES;
    decel_cfg     = DEFAULT_STAGES;
    cruise_cmd    = 16'h0100;
    sat_done      = 1'b0;

    directed_rows = '{
      row_known(16'h0000, 16'h0000, PH_STOP, 16'h0000, 1'b0),
      row_item(OP_TICK, 16'hFFFF, 16'hFFFF),           // ignored while stopped
      row_known(16'hFFFF, 16'hFFFF, PH_ACCEL, 16'h0000, 1'b0),
      row_write(REG_ACCEL_STAGES, 8'd0),               // zero acts as one stage
      row_write(REG_DECEL_STAGES, 8'd0),
      row_item(OP_TICK, 16'h0000, 16'h0000),
      row_known(16'hFFFF, 16'h0000, PH_STOP, 16'h0000, 1'b0),  // ramp done, no motion
      row_item(OP_UPDATE, 16'h1234, 16'h0005),         // restart with the old count
      row_item(OP_UPDATE, 16'h1234, 16'h0005),
      row_item(OP_TICK, 16'h0000, 16'h0000),           // ignored while cruising
      row_known(16'hFFFF, 16'h0000, PH_CONST, 16'hFFFF, 1'b1),
      row_item(OP_UPDATE, 16'hFFFF, 16'h0001),
      row_known(16'h0000, 16'h0000, PH_DECEL, 16'h0000, 1'b0),  // floored at zero
      row_write(REG_DECEL_STAGES, 8'd255),
      row_item(OP_UPDATE, 16'h0000, 16'h0000),
      row_item(OP_TICK, 16'h0000, 16'h0000),
      row_write(REG_DECEL_STAGES, 8'd1),
      row_known(16'h0000, 16'h0000, PH_STOP, 16'h0000, 1'b0),
      row_known(16'h0000, 16'hFFFF, PH_STOP, 16'h0000, 1'b0),
      row_write(REG_ACCEL_STAGES, 8'd255),
      row_write(REG_DECEL_STAGES, 8'd255),
      row_known(16'h8000, 16'hFFFF, PH_ACCEL, 16'h0000, 1'b0),
      row_write(REG_ABSENT, 8'd1),                     // unknown index, no effect
      row_item(OP_TICK, 16'h0000, 16'h0000),
      row_item(OP_UPDATE, 16'h8000, 16'h7FFF),
      row_item(OP_UPDATE, 16'hFFFF, 16'h0000)
    };

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        settle_idle();
        write_reg(directed_rows[i].addr, directed_rows[i].wdata);
      end else begin
        feed_item(directed_rows[i].op, directed_rows[i].cmd, directed_rows[i].meas,
                  directed_rows[i].typed, directed_rows[i].want);
      end
    end

    for (int p = 0; p < N_PLANS; p++) begin
      settle_idle();
      acc_v = PLAN_ACCEL[p];
      dec_v = PLAN_DECEL[p];
      if (p == N_PLANS - 1) begin
        acc_v = 8'($urandom_range(1, 12));
        dec_v = 8'($urandom_range(1, 12));
        write_reg(8'($urandom_range(2, 255)), 8'($urandom_range(0, 255)));
      end
      write_reg(REG_ACCEL_STAGES, acc_v);
      write_reg(REG_DECEL_STAGES, dec_v);
      no_gaps = (p % 3 == 0);
      counted = 0;
      while (counted < PLAN_BUDGET[p]) begin
        // long stage settings: once per run, tick a fresh ramp past saturation in one burst
        if (!sat_done && (acc_v > 8'd200 || dec_v > 8'd200) && stage_q == 8'd0 &&
            (phase_q == PH_ACCEL || phase_q == PH_DECEL)) begin
          burst    = $urandom_range(256, 280);
          sat_done = 1'b1;
          counted += burst;
          repeat (burst) feed_item(OP_TICK, '0, '0, 1'b0, '0);
        end else begin
          pick_item(op, cmd, meas);
          if (!(op == OP_TICK && (phase_q == PH_STOP || phase_q == PH_CONST))) counted++;
          feed_item(op, cmd, meas, 1'b0, '0);
        end
      end
    end

    settle_idle();
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin : result_sink
    ramp_result_t got;
    ramp_result_t want;
    int unsigned  stall;
    m_axis_tready = 1'b0;
    results_seen  = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = no_gaps ? 0 : $urandom_range(0, 4);
      // long hold-off so the block backs up into its input
      if (results_seen == 40 || results_seen == 250) stall = HOLD_CYCLES;
      if (stall != 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      results_seen++;
      got.ramp_phase     = m_axis_tdata[1:0];
      got.setpoint_speed = m_axis_tdata[17:2];
      got.stall_res      = m_axis_tdata[18];
      if (ramp_outcomes.size() == 0) begin
        flag_mismatch("unexpected transaction", '0, got.setpoint_speed);
      end else begin
        want = ramp_outcomes.pop_front();
        if (got.ramp_phase !== want.ramp_phase)
          flag_mismatch("ramp_phase", want.ramp_phase, got.ramp_phase);
        if (got.setpoint_speed !== want.setpoint_speed)
          flag_mismatch("setpoint_speed", want.setpoint_speed, got.setpoint_speed);
        if (got.stall_res !== want.stall_res)
          flag_mismatch("stall_res", want.stall_res, got.stall_res);
      end
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
hw/rtl/srsm_pkg.sv
hw/rtl/srsm_ucode_rom.sv
hw/rtl/srsm_datapath.sv
hw/rtl/speed_ramp_state_machine_unit.sv
tb/sv/speed_ramp_state_machine_unit_tb.sv
